FILE: src/mtes_pkg.sv
package mtes_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int IDX_W          = 3;
    localparam int TIME_W         = 32;
    localparam int ACT_W          = 2;

    localparam logic CMD_ARM     = 1'b0;
    localparam logic CMD_PROCESS = 1'b1;

    localparam logic [ACT_W-1:0] ACT_STOP    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd1;
    localparam logic [ACT_W-1:0] ACT_BREAK   = 2'd2;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  timer_index;
        logic [TIME_W-1:0] duration_ms;
        logic [ACT_W-1:0]  on_expiry;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  expired_index;
        logic [TIME_W-1:0] overshoot_ms;
        logic [TIME_W-1:0] wait_ms;
        logic              none_pending;
        logic              last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic arm_wr;
        logic scan_start;
        logic eval;
        logic idx_inc;
        logic fold_pend;
        logic emit_report;
        logic restart_calc;
        logic restart_wr;
        logic emit_summary;
        logic brk;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic             armed;
        logic             expired;
        logic [ACT_W-1:0] act;
        logic             last_idx;
        logic             out_free;
    } sts_t;

endpackage

FILE: src/mtes_ctrl.sv
module mtes_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_cmd,
    output logic           s_ready,
    input  mtes_pkg::sts_t sts,
    output mtes_pkg::ctl_t ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_REPORT,
        ST_RST_CALC,
        ST_RST_WRITE,
        ST_SUMMARY
    } state_t;

    state_t state_reg, state_next;
    logic   brk_reg, brk_next;

    always_comb begin
        state_next = state_reg;
        brk_next   = brk_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd == mtes_pkg::CMD_ARM) begin
                        ctl.arm_wr = 1'b1;
                    end else begin
                        ctl.scan_start = 1'b1;
                        brk_next       = 1'b0;
                        state_next     = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                ctl.eval = 1'b1;
                if (sts.armed && sts.expired) begin
                    state_next = ST_REPORT;
                end else begin
                    ctl.fold_pend = sts.armed;
                    if (sts.last_idx) begin
                        state_next = ST_SUMMARY;
                    end else begin
                        ctl.idx_inc = 1'b1;
                    end
                end
            end
            ST_REPORT: begin
                if (sts.out_free) begin
                    ctl.emit_report = 1'b1;
                    case (sts.act)
                        mtes_pkg::ACT_RESTART: state_next = ST_RST_CALC;
                        mtes_pkg::ACT_BREAK: begin
                            brk_next   = 1'b1;
                            state_next = ST_SUMMARY;
                        end
                        default: begin
                            if (sts.last_idx) begin
                                state_next = ST_SUMMARY;
                            end else begin
                                ctl.idx_inc = 1'b1;
                                state_next  = ST_EVAL;
                            end
                        end
                    endcase
                end
            end
            ST_RST_CALC: begin
                ctl.restart_calc = 1'b1;
                state_next       = ST_RST_WRITE;
            end
            ST_RST_WRITE: begin
                ctl.restart_wr = 1'b1;
                if (sts.last_idx) begin
                    state_next = ST_SUMMARY;
                end else begin
                    ctl.idx_inc = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_SUMMARY: begin
                ctl.brk = brk_reg;
                if (sts.out_free) begin
                    ctl.emit_summary = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            brk_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            brk_reg   <= brk_next;
        end
    end

endmodule

FILE: src/mtes_dpath.sv
module mtes_dpath #(
    parameter int NumTimers = mtes_pkg::NUM_TIMERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mtes_pkg::in_item_t  s_item,
    input  mtes_pkg::ctl_t      ctl,
    output mtes_pkg::sts_t      sts,
    output logic                m_valid,
    input  logic                m_ready,
    output mtes_pkg::out_item_t m_item
);

    localparam int AW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
    localparam int TW = mtes_pkg::TIME_W;

    logic [TW-1:0]                exp_mem [NumTimers];
    logic [TW-1:0]                per_mem [NumTimers];
    logic [mtes_pkg::ACT_W-1:0]   act_mem [NumTimers];
    logic [NumTimers-1:0]         vld_reg;

    logic [AW-1:0]                idx_reg, idx_next;
    logic [TW-1:0]                now_reg;
    logic [TW-1:0]                rd_end_reg, rd_per_reg;
    logic [mtes_pkg::ACT_W-1:0]   rd_act_reg;
    logic                         rd_vld_reg;
    logic [TW-1:0]                over_reg, wait_reg;
    logic [TW-1:0]                best_reg;
    logic                         have_reg;
    logic                         m_valid_reg;
    mtes_pkg::out_item_t          m_item_reg;

    logic                         arm_ok;
    logic [AW-1:0]                arm_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [TW-1:0]                wr_data;
    logic [TW-1:0]                pend_w, fold_w;
    logic                         fold_en;
    logic                         out_free;

    assign arm_ok   = int'(s_item.timer_index) < NumTimers;
    assign arm_addr = AW'(s_item.timer_index);

    always_comb begin
        if (ctl.scan_start) begin
            idx_next = '0;
        end else if (ctl.idx_inc) begin
            idx_next = idx_reg + AW'(1);
        end else begin
            idx_next = idx_reg;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;
        if (ctl.arm_wr) begin
            wr_en   = arm_ok;
            wr_addr = arm_addr;
            wr_data = s_item.now_ms + s_item.duration_ms;
        end else if (ctl.emit_report) begin
            wr_en = 1'b1;
        end else if (ctl.restart_wr) begin
            wr_en   = 1'b1;
            wr_data = now_reg + wait_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            exp_mem[wr_addr] <= wr_data;
        end
        if (ctl.arm_wr && arm_ok) begin
            per_mem[arm_addr] <= s_item.duration_ms;
            act_mem[arm_addr] <= s_item.on_expiry;
        end
        rd_end_reg <= exp_mem[idx_next];
        rd_per_reg <= per_mem[idx_next];
        rd_act_reg <= act_mem[idx_next];
        rd_vld_reg <= vld_reg[idx_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl.arm_wr && arm_ok) begin
            vld_reg[arm_addr] <= 1'b1;
        end
    end

    assign pend_w  = rd_end_reg - now_reg;
    assign fold_en = ctl.fold_pend || ctl.restart_wr;
    assign fold_w  = ctl.restart_wr ? wait_reg : pend_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            have_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (ctl.scan_start) begin
                have_reg <= 1'b0;
            end else if (fold_en) begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.scan_start) begin
            now_reg <= s_item.now_ms;
        end
        if (ctl.eval) begin
            over_reg <= now_reg - rd_end_reg;
        end
        if (ctl.restart_calc) begin
            wait_reg <= (rd_per_reg > over_reg) ? (rd_per_reg - over_reg) : TW'(1);
        end
        if (fold_en && (!have_reg || fold_w < best_reg)) begin
            best_reg <= fold_w;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.emit_report || ctl.emit_summary) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit_report) begin
            m_item_reg.kind          <= mtes_pkg::KIND_REPORT;
            m_item_reg.expired_index <= (mtes_pkg::IDX_W)'(idx_reg);
            m_item_reg.overshoot_ms  <= over_reg;
            m_item_reg.wait_ms       <= '0;
            m_item_reg.none_pending  <= 1'b0;
            m_item_reg.last          <= 1'b0;
        end else if (ctl.emit_summary) begin
            m_item_reg.kind          <= mtes_pkg::KIND_SUMMARY;
            m_item_reg.expired_index <= '0;
            m_item_reg.overshoot_ms  <= '0;
            m_item_reg.wait_ms       <= (!ctl.brk && have_reg) ? best_reg : '0;
            m_item_reg.none_pending  <= !ctl.brk && !have_reg;
            m_item_reg.last          <= 1'b1;
        end
    end

    assign sts.armed    = rd_vld_reg && (rd_end_reg != '0);
    assign sts.expired  = rd_end_reg <= now_reg;
    assign sts.act      = rd_act_reg;
    assign sts.last_idx = idx_reg == AW'(NumTimers - 1);
    assign sts.out_free = out_free;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: src/multi_timer_expiry_scanner.sv
// channel  direction  handshake          payload
// s_       in         s_valid / s_ready  in_item_t  (arm or process command)
// m_       out        m_valid / m_ready  out_item_t (expiry report or scan summary)
//
// an arm command gives no result
// a process command visits the timers in index order, adding a report step per
// expired timer and a calc and a write step per restart; while no report waits,
// one timer is visited per cycle, set by the registered read of the timer memory
// results wait in one output register; a stall on m_ready holds the scan
// aresetn is synchronous; it disarms all timers and empties the output register
module multi_timer_expiry_scanner #(
    parameter int NUM_TIMERS = mtes_pkg::NUM_TIMERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mtes_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output mtes_pkg::out_item_t m_item
);

    mtes_pkg::ctl_t ctl;
    mtes_pkg::sts_t sts;

    mtes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_item.cmd),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    mtes_dpath #(
        .NumTimers (NUM_TIMERS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .ctl     (ctl),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    a_busy_after_process: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.cmd == mtes_pkg::CMD_PROCESS |=> !s_ready)
        else $error("input taken while a scan runs");

    a_report_inside_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == mtes_pkg::KIND_REPORT |-> !s_ready && !m_item.last)
        else $error("expiry report outside a scan");

    a_summary_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == mtes_pkg::KIND_SUMMARY |->
            m_item.last && (!m_item.none_pending || m_item.wait_ms == '0))
        else $error("malformed scan summary");

    a_one_step_per_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !($onehot0({ctl.emit_report, ctl.emit_summary, ctl.arm_wr, ctl.scan_start}) == 1'b0))
        else $error("conflicting controller commands");

endmodule
